// ===== rtl/aabb_collide_and_push_out_assert.svh =====
// Assertion macros used by the checker of the collision block.
`ifndef AABB_COLLIDE_AND_PUSH_OUT_ASSERT_SVH
`define AABB_COLLIDE_AND_PUSH_OUT_ASSERT_SVH

// Checks a same-cycle implication while out of reset.
`define AABB_CPO_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Checks an implication in the next cycle while out of reset.
`define AABB_CPO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Checks an implication in the next cycle, also across reset.
`define AABB_CPO_ASSERT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/aabb_cpo_pkg.sv =====
`timescale 1ns / 1ps

package aabb_cpo_pkg;

    localparam int COORD_BITS   = 20;
    localparam int DIM_BITS     = 12;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;

    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    localparam logic [DIM_BITS-1:0] BOX_SIZE_RESET = DIM_BITS'(16);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_BOX_WIDTH  = 2'd0,
        REG_BOX_HEIGHT = 2'd1,
        REG_OFFSET_X   = 2'd2,
        REG_OFFSET_Y   = 2'd3
    } cfg_index_t;

    typedef enum logic {
        REQ_PLACE = 1'b0,
        REQ_TEST  = 1'b1
    } req_type_t;

    typedef enum logic [1:0] {
        SIDE_LEFT  = 2'd0,
        SIDE_RIGHT = 2'd1,
        SIDE_TOP   = 2'd2,
        SIDE_DOWN  = 2'd3
    } side_t;

    typedef struct packed {
        logic                         req_type;
        logic signed [COORD_BITS-1:0] place_x;
        logic signed [COORD_BITS-1:0] place_y;
        logic signed [COORD_BITS-1:0] other_min_x;
        logic signed [COORD_BITS-1:0] other_min_y;
        logic [DIM_BITS-1:0]          other_width;
        logic [DIM_BITS-1:0]          other_height;
        logic                         other_enabled;
        logic                         other_is_piece;
    } in_item_t;

    typedef struct packed {
        logic                         colliding;
        logic                         piece_notify;
        side_t                        push_side;
        logic signed [COORD_BITS-1:0] push_dist;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
    } out_item_t;

    typedef struct packed {
        logic [DIM_BITS-1:0]          box_width;
        logic [DIM_BITS-1:0]          box_height;
        logic signed [COORD_BITS-1:0] offset_x;
        logic signed [COORD_BITS-1:0] offset_y;
    } box_cfg_t;

endpackage

// ===== rtl/aabb_cpo_resolve.sv =====
`timescale 1ns / 1ps

module aabb_cpo_resolve #(
    parameter int FRAC_BITS = 4
) (
    input  aabb_cpo_pkg::in_item_t                     item,
    input  aabb_cpo_pkg::box_cfg_t                     cfg,
    input  logic signed [aabb_cpo_pkg::COORD_BITS-1:0] actor_x,
    input  logic signed [aabb_cpo_pkg::COORD_BITS-1:0] actor_y,
    output aabb_cpo_pkg::out_item_t                    result
);
    import aabb_cpo_pkg::*;

    localparam int W    = COORD_BITS;
    localparam int SZ_W = DIM_BITS + FRAC_BITS;
    localparam int EW   = ((W + 1 > SZ_W) ? W + 1 : SZ_W) + 2;
    localparam int DW   = EW + 1;

    logic [SZ_W-1:0]        a_w, a_h, b_w, b_h;
    logic signed [EW-1:0]   a_min_x, a_min_y, a_max_x, a_max_y;
    logic signed [EW-1:0]   b_min_x, b_min_y, b_max_x, b_max_y;
    logic                   hit;
    logic signed [DW-1:0]   c0, c1, c2, c3, c01, c23, c_sel;
    logic [DW-1:0]          m0, m1, m2, m3, m01, m23;
    side_t                  s01, s23, s_sel;
    logic                   dist_fits, pos_fits;
    logic signed [W-1:0]    dist_sat;
    logic signed [W:0]      axis_sum;
    logic signed [W-1:0]    axis_new;

    // Edges are wide enough that no sum or difference can wrap.
    assign a_w = SZ_W'(cfg.box_width) << FRAC_BITS;
    assign a_h = SZ_W'(cfg.box_height) << FRAC_BITS;
    assign b_w = SZ_W'(item.other_width) << FRAC_BITS;
    assign b_h = SZ_W'(item.other_height) << FRAC_BITS;

    assign a_min_x = EW'(actor_x) + EW'(cfg.offset_x);
    assign a_min_y = EW'(actor_y) + EW'(cfg.offset_y);
    assign a_max_x = a_min_x + signed'(EW'(a_w));
    assign a_max_y = a_min_y + signed'(EW'(a_h));
    assign b_min_x = EW'(item.other_min_x);
    assign b_min_y = EW'(item.other_min_y);
    assign b_max_x = b_min_x + signed'(EW'(b_w));
    assign b_max_y = b_min_y + signed'(EW'(b_h));

    assign hit = !((a_max_x <= b_min_x) || (b_max_x <= a_min_x) ||
                   (a_max_y <= b_min_y) || (b_max_y <= a_min_y));

    assign c0 = DW'(b_max_x) - DW'(a_min_x);
    assign c1 = DW'(b_min_x) - DW'(a_max_x);
    assign c2 = DW'(b_max_y) - DW'(a_min_y);
    assign c3 = DW'(b_min_y) - DW'(a_max_y);

    assign m0 = c0[DW-1] ? unsigned'(-c0) : unsigned'(c0);
    assign m1 = c1[DW-1] ? unsigned'(-c1) : unsigned'(c1);
    assign m2 = c2[DW-1] ? unsigned'(-c2) : unsigned'(c2);
    assign m3 = c3[DW-1] ? unsigned'(-c3) : unsigned'(c3);

    // Pairwise minimum; the later side wins only when strictly smaller,
    // so the first side of equal magnitude is kept.
    always_comb begin
        if (m1 < m0) begin
            m01 = m1; c01 = c1; s01 = SIDE_RIGHT;
        end else begin
            m01 = m0; c01 = c0; s01 = SIDE_LEFT;
        end
        if (m3 < m2) begin
            m23 = m3; c23 = c3; s23 = SIDE_DOWN;
        end else begin
            m23 = m2; c23 = c2; s23 = SIDE_TOP;
        end
        if (m23 < m01) begin
            c_sel = c23; s_sel = s23;
        end else begin
            c_sel = c01; s_sel = s01;
        end
    end

    assign dist_fits = (&c_sel[DW-1:W-1]) || !(|c_sel[DW-1:W-1]);
    assign dist_sat  = dist_fits ? c_sel[W-1:0] : (c_sel[DW-1] ? COORD_MIN : COORD_MAX);

    assign axis_sum = s_sel[1] ? ((W+1)'(actor_y) + (W+1)'(dist_sat))
                               : ((W+1)'(actor_x) + (W+1)'(dist_sat));
    assign pos_fits = (axis_sum[W] == axis_sum[W-1]);
    assign axis_new = pos_fits ? axis_sum[W-1:0] : (axis_sum[W] ? COORD_MIN : COORD_MAX);

    always_comb begin
        result.colliding    = 1'b0;
        result.piece_notify = 1'b0;
        result.push_side    = SIDE_LEFT;
        result.push_dist    = '0;
        result.pos_x        = actor_x;
        result.pos_y        = actor_y;
        if (item.req_type == REQ_PLACE) begin
            result.pos_x = item.place_x;
            result.pos_y = item.place_y;
        end else if (item.other_enabled && hit) begin
            result.colliding = 1'b1;
            if (item.other_is_piece) begin
                result.piece_notify = 1'b1;
            end else begin
                result.push_side = s_sel;
                result.push_dist = dist_sat;
                if (s_sel[1]) begin
                    result.pos_y = axis_new;
                end else begin
                    result.pos_x = axis_new;
                end
            end
        end
    end

endmodule

// ===== rtl/aabb_collide_and_push_out.sv =====
`timescale 1ns / 1ps

// Keeps the position of one axis-aligned box and resolves it against other
// boxes: a place transaction sets the position, a test transaction checks
// strict overlap and pushes the box out along the shortest of the four
// directions, with saturation. Each accepted transaction gives exactly one
// result through the input and result registers; a new one is accepted every
// cycle unless the output stalls, and the position written by one transaction
// is used by the very next one, since the overlap, push and update logic
// closes its loop through the position register. Configuration writes take
// effect at the next edge and must only be made while the block is idle.
module aabb_collide_and_push_out #(
    parameter int FRAC_BITS = 4
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       s_valid,
    output logic                                       s_ready,
    input  aabb_cpo_pkg::in_item_t                     s_data,
    output logic                                       m_valid,
    input  logic                                       m_ready,
    output aabb_cpo_pkg::out_item_t                    m_data,
    input  logic                                       cfg_we,
    input  logic [aabb_cpo_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [aabb_cpo_pkg::CFG_DATA_BITS-1:0]     cfg_wdata
);
    import aabb_cpo_pkg::*;

    logic                         in_valid_reg, in_valid_next;
    in_item_t                     in_item_reg;
    logic                         out_valid_reg, out_valid_next;
    out_item_t                    out_item_reg;
    logic signed [COORD_BITS-1:0] actor_x_reg, actor_x_next;
    logic signed [COORD_BITS-1:0] actor_y_reg, actor_y_next;
    box_cfg_t                     cfg_reg, cfg_next;
    out_item_t                    result;
    logic                         fire;

    aabb_cpo_resolve #(
        .FRAC_BITS (FRAC_BITS)
    ) u_resolve (
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .actor_x (actor_x_reg),
        .actor_y (actor_y_reg),
        .result  (result)
    );

    // The held transaction moves to the result register whenever it is free.
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        actor_x_next   = actor_x_reg;
        actor_y_next   = actor_y_reg;
        if (fire) begin
            actor_x_next = result.pos_x;
            actor_y_next = result.pos_y;
        end
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                REG_BOX_WIDTH:  cfg_next.box_width  = cfg_wdata[DIM_BITS-1:0];
                REG_BOX_HEIGHT: cfg_next.box_height = cfg_wdata[DIM_BITS-1:0];
                REG_OFFSET_X:   cfg_next.offset_x   = cfg_wdata[COORD_BITS-1:0];
                REG_OFFSET_Y:   cfg_next.offset_y   = cfg_wdata[COORD_BITS-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            actor_x_reg        <= '0;
            actor_y_reg        <= '0;
            cfg_reg.box_width  <= BOX_SIZE_RESET;
            cfg_reg.box_height <= BOX_SIZE_RESET;
            cfg_reg.offset_x   <= '0;
            cfg_reg.offset_y   <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            actor_x_reg   <= actor_x_next;
            actor_y_reg   <= actor_y_next;
            cfg_reg       <= cfg_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
        if (fire) begin
            out_item_reg <= result;
        end
    end

endmodule

// ===== rtl/aabb_cpo_checker.sv =====
`timescale 1ns / 1ps

`include "aabb_collide_and_push_out_assert.svh"

module aabb_cpo_checker (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       s_valid,
    input  logic                                       s_ready,
    input  logic                                       m_valid,
    input  logic                                       m_ready,
    input  aabb_cpo_pkg::out_item_t                    m_data
);
    import aabb_cpo_pkg::*;

    // A stalled result transaction holds its valid and its payload.
    `AABB_CPO_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")

    // Reset leaves no result pending.
    `AABB_CPO_ASSERT_ALWAYS(a_reset_empty, !aresetn, !m_valid, "result valid right after reset")

    // Input is refused only while a result is waiting on the output.
    `AABB_CPO_ASSERT_NOW(a_refuse_only_stalled, !s_ready, m_valid && !m_ready, "input refused without output stall")

    // With the output stalled, a transaction taken in fills the single input stage.
    `AABB_CPO_ASSERT_NEXT(a_stage_full, s_valid && s_ready && m_valid && !m_ready, m_ready || !s_ready, "input stage accepted beyond its depth")

endmodule

bind aabb_collide_and_push_out aabb_cpo_checker u_checker (.*);
